// ===== hw/rtl/rdns_pkg.sv =====
// Shared types, character codes and suffix tables for the reverse-name decoder.
`timescale 1ns / 1ps

package rdns_pkg;

  localparam int MAX_NAME_LEN_DEF = 75;

  // Wide enough to hold any character position up to 255 + 1.
  localparam int POS_W = 9;

  localparam int KIND_W       = 2;
  localparam int HALF_W       = 64;
  localparam int OUT_TDATA_W  = 136;
  localparam int OUT_PAYLOAD_W = KIND_W + 2 * HALF_W;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IPV4 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IPV6 = 2'd2;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  // Bitstring label layout: "\[x" then 32 hex digits then '/'.
  localparam logic [POS_W-1:0] BS_POS_BSLASH = 9'd0;
  localparam logic [POS_W-1:0] BS_POS_LBRACK = 9'd1;
  localparam logic [POS_W-1:0] BS_POS_X      = 9'd2;
  localparam logic [POS_W-1:0] BS_POS_HEX_HI = 9'd34;
  localparam logic [POS_W-1:0] BS_POS_SLASH  = 9'd35;
  localparam logic [POS_W-1:0] BS_MIN_LEN    = 9'd36;

  // Suffix matcher bit positions.
  localparam int M_INADDR = 0;
  localparam int M_ARPA   = 1;
  localparam int M_IP6    = 2;
  localparam int M_INT    = 3;
  localparam int NUM_SUFFIX = 4;

  localparam logic [7:0] SUFFIX_TEXT [NUM_SUFFIX][8] = '{
    '{"i", "n", "-", "a", "d", "d", "r", 8'h00},
    '{"a", "r", "p", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "p", "6", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] SUFFIX_LEN [NUM_SUFFIX] = '{4'd7, 4'd4, 4'd3, 4'd3};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HALF_W-1:0] upper;
    logic [HALF_W-1:0] lower;
  } res_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  // Prefix-match bits that also have the full suffix length.
  function automatic logic [NUM_SUFFIX-1:0] exact_match(input logic [NUM_SUFFIX-1:0] pre,
                                                        input logic [3:0] len);
    logic [NUM_SUFFIX-1:0] eq;
    for (int t = 0; t < NUM_SUFFIX; t++) begin
      eq[t] = pre[t] && (len == SUFFIX_LEN[t]);
    end
    return eq;
  endfunction

endpackage

// ===== hw/rtl/rdns_scan.sv =====
// Per-character scanner: label matchers, value shifters and the end-of-name decision.
`timescale 1ns / 1ps

module rdns_scan
  import rdns_pkg::*;
#(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] name_char,
  input  logic       last_char,
  output res_t       res
);

  localparam int CNT_W = $clog2(MAX_NAME_LEN + 2);

  typedef struct packed {
    logic cur_dig;
    logic cur_hex;
    logic prev_dig;
    logic prev_hex1;
    logic v4_ok;
    logic v6_ok;
    logic bs_pre;
    logic bs_ok;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{cur_dig: 1'b1, cur_hex: 1'b0, prev_dig: 1'b0,
                                     prev_hex1: 1'b0, v4_ok: 1'b1, v6_ok: 1'b1,
                                     bs_pre: 1'b1, bs_ok: 1'b1};

  logic [CNT_W-1:0]      char_count, char_count_next;
  logic [1:0]            label_count, label_count_next;
  logic [NUM_SUFFIX-1:0] match_cur, match_cur_next;
  logic [NUM_SUFFIX-1:0] match_prev, match_prev_next;
  logic [7:0]            val_cur, val_cur_next;
  logic [7:0]            val_prev, val_prev_next;
  logic [3:0]            len_cur, len_cur_next;
  logic [3:0]            nib_cur, nib_cur_next;
  logic [3:0]            nib_prev, nib_prev_next;
  logic [31:0]           ipv4_shift, ipv4_shift_next;
  logic [127:0]          nibble_shift, nibble_shift_next;
  logic [127:0]          bs_accum, bs_accum_next;
  flags_t                flags, flags_next;

  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      count_ext;
  logic [4:0]            hexd;
  logic [7:0]            lc;
  logic                  is_dig;
  logic [NUM_SUFFIX-1:0] last_eq;

  always_comb begin
    pos    = POS_W'(char_count);
    hexd   = hex_digit(name_char);
    lc     = (name_char >= "A" && name_char <= "Z") ? name_char + 8'd32 : name_char;
    is_dig = name_char >= "0" && name_char <= "9";

    char_count_next   = char_count;
    label_count_next  = label_count;
    match_cur_next    = match_cur;
    match_prev_next   = match_prev;
    val_cur_next      = val_cur;
    val_prev_next     = val_prev;
    len_cur_next      = len_cur;
    nib_cur_next      = nib_cur;
    nib_prev_next     = nib_prev;
    ipv4_shift_next   = ipv4_shift;
    nibble_shift_next = nibble_shift;
    bs_accum_next     = bs_accum;
    flags_next        = flags;

    // bitstring label, tracked by absolute position in the name
    priority if (pos == BS_POS_BSLASH) begin
      if (name_char != CH_BSLASH) flags_next.bs_pre = 1'b0;
    end else if (pos == BS_POS_LBRACK) begin
      if (name_char != CH_LBRACK) flags_next.bs_pre = 1'b0;
    end else if (pos == BS_POS_X) begin
      if (name_char != CH_LOW_X && name_char != CH_UP_X) flags_next.bs_pre = 1'b0;
    end else if (pos <= BS_POS_HEX_HI) begin
      if (!hexd[4]) begin
        flags_next.bs_ok = 1'b0;
      end else begin
        bs_accum_next = {bs_accum[123:0], hexd[3:0]};
      end
    end else if (pos == BS_POS_SLASH) begin
      if (name_char != CH_SLASH) flags_next.bs_ok = 1'b0;
    end else begin
    end

    if (char_count < CNT_W'(MAX_NAME_LEN + 1)) char_count_next = char_count + 1'b1;

    if (name_char == CH_DOT) begin
      // commit the previous label, then retire the current one into its place
      if (label_count != 2'd0) begin
        if (!flags.prev_dig) flags_next.v4_ok = 1'b0;
        ipv4_shift_next = {val_prev, ipv4_shift[31:8]};
        if (!flags.prev_hex1) flags_next.v6_ok = 1'b0;
        nibble_shift_next = {nib_prev, nibble_shift[127:4]};
      end
      match_prev_next      = exact_match(match_cur, len_cur);
      val_prev_next        = val_cur;
      nib_prev_next        = nib_cur;
      flags_next.prev_dig  = flags.cur_dig;
      flags_next.prev_hex1 = flags.cur_hex && (len_cur == 4'd1);
      match_cur_next       = '1;
      val_cur_next         = 8'd0;
      len_cur_next         = 4'd0;
      nib_cur_next         = 4'd0;
      flags_next.cur_dig   = 1'b1;
      flags_next.cur_hex   = 1'b0;
      if (label_count != 2'd3) label_count_next = label_count + 1'b1;
    end else begin
      for (int t = 0; t < NUM_SUFFIX; t++) begin
        if (len_cur >= SUFFIX_LEN[t] || SUFFIX_TEXT[t][len_cur[2:0]] != lc) begin
          match_cur_next[t] = 1'b0;
        end
      end
      if (is_dig) begin
        val_cur_next = (val_cur << 3) + (val_cur << 1) + 8'(name_char - "0");
      end else begin
        flags_next.cur_dig = 1'b0;
      end
      if (len_cur == 4'd0 && hexd[4]) begin
        flags_next.cur_hex = 1'b1;
        nib_cur_next       = hexd[3:0];
      end
      if (len_cur != 4'd15) len_cur_next = len_cur + 1'b1;
    end

    // decision on the updated state
    last_eq   = exact_match(match_cur_next, len_cur_next);
    count_ext = POS_W'(char_count_next);
    res       = '{kind: KIND_NONE, upper: '0, lower: '0};
    if (char_count_next <= CNT_W'(MAX_NAME_LEN) && label_count_next >= 2'd2) begin
      if (last_eq[M_ARPA] && match_prev_next[M_INADDR]) begin
        if (flags_next.v4_ok) begin
          res.kind  = KIND_IPV4;
          res.upper = {ipv4_shift_next, 32'd0};
        end
      end else if (match_prev_next[M_IP6] && (last_eq[M_INT] || last_eq[M_ARPA])) begin
        if (flags_next.bs_pre) begin
          if (flags_next.bs_ok && count_ext >= BS_MIN_LEN) begin
            res.kind  = KIND_IPV6;
            res.upper = bs_accum_next[127:64];
            res.lower = bs_accum_next[63:0];
          end
        end else if (flags_next.v6_ok) begin
          res.kind  = KIND_IPV6;
          res.upper = nibble_shift_next[127:64];
          res.lower = nibble_shift_next[63:0];
        end
      end
    end
  end

  // the last character returns every matcher to its start state for the next name
  always_ff @(posedge clk) begin
    if (rst || (take && last_char)) begin
      char_count   <= '0;
      label_count  <= 2'd0;
      match_cur    <= '1;
      match_prev   <= '0;
      val_cur      <= 8'd0;
      val_prev     <= 8'd0;
      len_cur      <= 4'd0;
      nib_cur      <= 4'd0;
      nib_prev     <= 4'd0;
      ipv4_shift   <= 32'd0;
      nibble_shift <= 128'd0;
      bs_accum     <= 128'd0;
      flags        <= FLAGS_RESET;
    end else if (take) begin
      char_count   <= char_count_next;
      label_count  <= label_count_next;
      match_cur    <= match_cur_next;
      match_prev   <= match_prev_next;
      val_cur      <= val_cur_next;
      val_prev     <= val_prev_next;
      len_cur      <= len_cur_next;
      nib_cur      <= nib_cur_next;
      nib_prev     <= nib_prev_next;
      ipv4_shift   <= ipv4_shift_next;
      nibble_shift <= nibble_shift_next;
      bs_accum     <= bs_accum_next;
      flags        <= flags_next;
    end
  end

endmodule

// ===== hw/rtl/rdns_skid.sv =====
// Result register with a skid stage between the scanner and the output channel.
`timescale 1ns / 1ps

module rdns_skid
  import rdns_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // skid_valid blocks push, so at most one source refills the output
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== hw/rtl/reverse_dns_name_to_address.sv =====
// Top level of the reverse-lookup name decoder: character scanner and result buffer.
//
//  channel | direction | transfer content
//  s_*     | in        | one name character, s_tlast on the final one
//  m_*     | out       | one result per name: kind and 128-bit address
//
// One character is taken per cycle while s_tready is high; the scanner
// updates its matchers and shifters in that cycle. The result is registered
// into the output register, or into the skid register while the output stalls.
// rst clears all scan state and both output stages. s_tready falls only while
// both registers hold results, so an output stall costs input cycles only then.
`timescale 1ns / 1ps

module reverse_dns_name_to_address
  import rdns_pkg::*;
#(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] name_char
  input  logic                   s_tlast,   // last_char
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] addr_kind, [65:2] addr_upper,
                                            // [129:66] addr_lower, rest zero
);

  logic take;
  res_t res;
  res_t out_res;

  assign take = s_tvalid && s_tready;

  rdns_scan #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .name_char(s_tdata),
    .last_char(s_tlast),
    .res      (res)
  );

  rdns_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && s_tlast),
    .push_data (res),
    .push_ready(s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {(OUT_TDATA_W - OUT_PAYLOAD_W)'(0), out_res.lower, out_res.upper,
                    out_res.kind};

endmodule
